>>> sv/three_wire_adc_command_master_core_macros.svh
// Assertion macros shared by the three-wire ADC command master RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef THREE_WIRE_ADC_COMMAND_MASTER_CORE_MACROS_SVH
`define THREE_WIRE_ADC_COMMAND_MASTER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TWADC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("twadc assertion failed");

// next-cycle implication, checked outside reset
`define TWADC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("twadc assertion failed");

`endif

>>> sv/twadc_pkg.sv
// Shared types, constants and the frame program table of the three-wire ADC master.
// Depends on nothing; used by twadc_seq and the top level.
`timescale 1ns / 1ps

package twadc_pkg;

    // receive length of a conversion or digital read
    localparam int READ_BITS = 8;
    localparam int LEN_W     = 5;
    localparam logic [LEN_W-1:0] RECV_LEN = LEN_W'(READ_BITS);

    // command bytes, opcode in the top three bits
    localparam logic [7:0] OP_CTRL   = 8'h60;
    localparam logic [7:0] OP_PWDN   = 8'h00;
    localparam logic [7:0] OP_WAKE   = 8'h40;
    localparam logic [7:0] OP_ATTR   = 8'h20;
    localparam logic [7:0] OP_CONV   = 8'h80;
    localparam logic [7:0] OP_DIG    = 8'ha0;
    localparam logic [3:0] PWDN_CTRL = 4'h0;

    // request types
    localparam logic [1:0] REQ_SETUP   = 2'd0;
    localparam logic [1:0] REQ_PWDN    = 2'd1;
    localparam logic [1:0] REQ_CONVERT = 2'd2;
    localparam logic [1:0] REQ_DIGITAL = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_NIBBLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAKEUP_MASK    = 2'd2;

    typedef enum logic [2:0] {
        K_END   = 3'd0,
        K_SEND  = 3'd1,
        K_PULSE = 3'd2,
        K_RECV  = 3'd3,
        K_IDLE  = 3'd4
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t        kind;
        logic [LEN_W-1:0] len;
        logic [7:0]       val;
    } seg_t;

    typedef struct packed {
        logic [3:0] control_nibble;
        logic [7:0] attribute_mask;
        logic [7:0] wakeup_mask;
    } cfg_t;

    typedef struct packed {
        logic       dio_in;
        logic [2:0] channel;
        logic [1:0] req_type;
        logic       req_valid;
    } req_t;

    typedef struct packed {
        logic       req_accepted;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       dio_level;
        logic       dio_drive;
        logic       clk_pulse;
        logic       start_level;
    } res_t;

    function automatic seg_t mk_seg(seg_kind_t kind, logic [LEN_W-1:0] len, logic [7:0] val);
        seg_t s;
        s.kind = kind;
        s.len  = len;
        s.val  = val;
        return s;
    endfunction

    // frame program of each request type, one segment per index
    function automatic seg_t seg_at(logic [1:0] req, logic [5:0] idx, cfg_t cfg,
                                    logic [2:0] chan);
        seg_t s;
        s = mk_seg(K_END, 5'd1, 8'h00);
        case (req)
            REQ_SETUP: begin
                case (idx)
                    6'd0: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_CTRL[7:5]});
                    6'd1: s = mk_seg(K_SEND, 5'd4, {4'd0, cfg.control_nibble});
                    6'd2: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    6'd3: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_ATTR[7:5]});
                    6'd4: s = mk_seg(K_SEND, 5'd8, cfg.attribute_mask);
                    6'd5: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    6'd6: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_WAKE[7:5]});
                    6'd7: s = mk_seg(K_SEND, 5'd8, cfg.wakeup_mask);
                    6'd8: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    default: s = mk_seg(K_END, 5'd1, 8'h00);
                endcase
            end
            REQ_PWDN: begin
                case (idx)
                    6'd0: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_CTRL[7:5]});
                    6'd1: s = mk_seg(K_SEND, 5'd4, {4'd0, PWDN_CTRL});
                    6'd2: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    6'd3: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_PWDN[7:5]});
                    6'd4: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    default: s = mk_seg(K_END, 5'd1, 8'h00);
                endcase
            end
            REQ_CONVERT: begin
                case (idx)
                    6'd0: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_CONV[7:5]});
                    6'd1: s = mk_seg(K_SEND, 5'd4, {4'd0, chan, 1'b0});
                    6'd2: s = mk_seg(K_PULSE, 5'd1, 8'h00);
                    6'd3: s = mk_seg(K_RECV, RECV_LEN, 8'h00);
                    6'd4: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    default: s = mk_seg(K_END, 5'd1, 8'h00);
                endcase
            end
            REQ_DIGITAL: begin
                case (idx)
                    6'd0: s = mk_seg(K_SEND, 5'd3, {5'd0, OP_DIG[7:5]});
                    6'd1: s = mk_seg(K_RECV, RECV_LEN, 8'h00);
                    6'd2: s = mk_seg(K_IDLE, 5'd1, 8'h00);
                    default: s = mk_seg(K_END, 5'd1, 8'h00);
                endcase
            end
            default: s = mk_seg(K_END, 5'd1, 8'h00);
        endcase
        return s;
    endfunction

endpackage

>>> sv/twadc_seq.sv
// Frame sequencer of the three-wire ADC master: sequence state and one-slot step logic.
// Depends on twadc_pkg and three_wire_adc_command_master_core_macros.svh.
`timescale 1ns / 1ps
`include "three_wire_adc_command_master_core_macros.svh"

module twadc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  twadc_pkg::req_t   req_in,
    input  twadc_pkg::cfg_t   cfg,
    output twadc_pkg::res_t   res
);

    logic [5:0] seq_reg, seq_next;
    logic [3:0] bp_reg, bp_next;
    logic [7:0] sb_reg, sb_next;
    logic [1:0] act_reg, act_next;
    logic [2:0] chan_reg, chan_next;

    twadc_pkg::seg_t cur_seg;
    twadc_pkg::seg_t nxt_seg;

    // one bit slot: take a request when idle, then play the current segment
    always_comb begin
        logic [twadc_pkg::LEN_W-1:0] bp;
        logic [twadc_pkg::LEN_W-1:0] amt;
        seq_next  = seq_reg;
        act_next  = act_reg;
        chan_next = chan_reg;
        sb_next   = sb_reg;
        bp        = {1'b0, bp_reg};
        amt       = '0;
        cur_seg   = twadc_pkg::mk_seg(twadc_pkg::K_END, 5'd1, 8'h00);
        nxt_seg   = twadc_pkg::mk_seg(twadc_pkg::K_END, 5'd1, 8'h00);
        res       = '0;
        res.start_level = 1'b1;

        if (seq_reg == 6'd0 && req_in.req_valid) begin
            act_next         = req_in.req_type;
            chan_next        = req_in.channel;
            seq_next         = 6'd1;
            bp               = '0;
            sb_next          = 8'h00;
            res.req_accepted = 1'b1;
        end

        if (seq_next != 6'd0) begin
            res.busy_res = 1'b1;
            cur_seg = twadc_pkg::seg_at(act_next, seq_next - 6'd1, cfg, chan_next);
            if (bp >= cur_seg.len) begin
                bp = '0;
            end
            case (cur_seg.kind)
                twadc_pkg::K_SEND: begin
                    res.start_level = 1'b0;
                    res.clk_pulse   = 1'b1;
                    res.dio_drive   = 1'b1;
                    amt             = cur_seg.len - 5'd1 - bp;
                    res.dio_level   = cur_seg.val[amt[2:0]];
                end
                twadc_pkg::K_PULSE: begin
                    res.start_level = 1'b0;
                    res.clk_pulse   = 1'b1;
                    res.dio_drive   = 1'b1;
                end
                twadc_pkg::K_RECV: begin
                    res.start_level = 1'b0;
                    res.clk_pulse   = 1'b1;
                    sb_next         = {sb_next[6:0], req_in.dio_in};
                    if (bp + 5'd1 == cur_seg.len) begin
                        res.read_valid = 1'b1;
                        res.read_data  = sb_next;
                    end
                end
                default: begin
                end
            endcase
            bp = bp + 5'd1;
            // segment done: move on, drop back to idle after the last one
            if (bp >= cur_seg.len || cur_seg.kind == twadc_pkg::K_END) begin
                bp       = '0;
                seq_next = seq_next + 6'd1;
                nxt_seg  = twadc_pkg::seg_at(act_next, seq_next - 6'd1, cfg, chan_next);
                if (nxt_seg.kind == twadc_pkg::K_END) begin
                    seq_next = 6'd0;
                end
            end
        end
        bp_next = bp[3:0];
    end

    // sequence state, advanced once per accepted slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg  <= '0;
            bp_reg   <= '0;
            sb_reg   <= '0;
            act_reg  <= '0;
            chan_reg <= '0;
        end else if (advance) begin
            seq_reg  <= seq_next;
            bp_reg   <= bp_next;
            sb_reg   <= sb_next;
            act_reg  <= act_next;
            chan_reg <= chan_next;
        end
    end

    // state holds between accepted slots
    `TWADC_ASSERT_NEXT(a_hold_when_stalled, aclk, aresetn, !advance,
        $stable(seq_reg) && $stable(bp_reg) && $stable(sb_reg))
    // idle slot without a request stays idle
    `TWADC_ASSERT_NEXT(a_idle_stays_idle, aclk, aresetn,
        advance && seq_reg == 6'd0 && !req_in.req_valid, seq_reg == 6'd0)
    // a taken request sits in its opcode segment afterward
    `TWADC_ASSERT_NEXT(a_request_starts, aclk, aresetn,
        advance && seq_reg == 6'd0 && req_in.req_valid, seq_reg == 6'd1 && bp_reg == 4'd1)
    // a request is only taken when the sequencer was idle
    `TWADC_ASSERT_NOW(a_accept_only_idle, aclk, aresetn,
        res.req_accepted, seq_reg == 6'd0 && res.busy_res)

endmodule

>>> sv/three_wire_adc_command_master_core.sv
// Three-wire serial ADC command master: one input beat per bit slot, one result beat back.
// Each accepted beat advances the frame sequencer (twadc_seq) by one slot and the slot's
// line levels are stored in an output register; while a result is held, the next beat
// is taken in the same cycle the stored result is taken, so the block runs at one beat
// per clock as long as results are taken. Configuration writes should be made while no
// request sequence is running. Depends on twadc_pkg and twadc_seq.
`timescale 1ns / 1ps

module three_wire_adc_command_master_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request slot input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // req_valid, req_type[1:0],
                                                           // channel[2:0], dio_in, 0
    // slot result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // start_level, clk_pulse,
                                                           // dio_drive, dio_level,
                                                           // read_valid, read_data[7:0],
                                                           // busy_res, req_accepted, 0
    // configuration write port
    input  logic                                cfg_we,
    input  logic [twadc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                          cfg_wdata
);

    twadc_pkg::cfg_t cfg_reg;
    twadc_pkg::req_t req_in;
    twadc_pkg::res_t res;
    twadc_pkg::res_t out_reg;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                twadc_pkg::REG_CONTROL_NIBBLE: cfg_reg.control_nibble <= cfg_wdata[3:0];
                twadc_pkg::REG_ATTRIBUTE_MASK: cfg_reg.attribute_mask <= cfg_wdata;
                twadc_pkg::REG_WAKEUP_MASK:    cfg_reg.wakeup_mask    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input beat unpacking and handshake
    assign req_in   = twadc_pkg::req_t'(s_tdata[6:0]);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign advance  = s_tvalid && s_tready;

    twadc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req_in  (req_in),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // output register
    always_comb begin
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

>>> verif/three_wire_adc_command_master_core_tb.sv
// Self-checking testbench for the three-wire ADC command master core: a directed table,
// then randomized request traffic under three idle patterns, checked by a slot predictor.
// Depends on twadc_pkg and three_wire_adc_command_master_core.
`timescale 1ns / 1ps

module three_wire_adc_command_master_core_tb;

    // unlisted register index, a write there must change nothing
    localparam logic [twadc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // slot levels that can be read off directly
    localparam twadc_pkg::res_t SLOT_IDLE        = 15'h0001;  // start high, all else low
    localparam twadc_pkg::res_t SLOT_SETUP_FIRST = 15'h6006;  // taken, busy, clock, msb 0
    localparam int   LONG_HOLD        = 300;
    localparam int   STALL_LIMIT      = 2000;
    localparam int   PHASES           = 12;
    localparam int   BEATS_PER_PHASE  = 100;

    typedef struct packed {
        logic            settle;    // run idle ticks afterwards until the sequence ends
        logic            has_exp;
        twadc_pkg::res_t exp;
        twadc_pkg::req_t beat;
    } stim_row_t;

    typedef struct {
        twadc_pkg::seg_kind_t kind;
        int unsigned          len;
        logic [7:0]           bits;
    } frame_seg_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;  // req_valid, req_type[1:0], channel[2:0], dio_in, 0
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // start_level, clk_pulse, dio_drive, dio_level,
                                     // read_valid, read_data[7:0], busy_res, req_accepted, 0
    logic                            cfg_we    = 1'b0;
    logic [twadc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                      cfg_wdata = 8'h00;

    // predictor copy of the sequencer and the registers
    logic [5:0]  frame_idx;
    int unsigned bit_idx;
    logic [7:0]  rx_byte;
    logic [1:0]  run_req;
    logic [2:0]  run_chan;
    logic [3:0]  ctrl_nibble;
    logic [7:0]  attr_mask;
    logic [7:0]  wake_mask;

    twadc_pkg::res_t expected_slots[$];
    int              mismatches = 0;
    int              send_gap_pct = 0;
    int              recv_gap_pct = 0;
    int              hold_request = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              stall_cycles = 0;
    stim_row_t       dir_rows [11];
    twadc_pkg::req_t next_beat;
    twadc_pkg::res_t mon_got;
    twadc_pkg::res_t mon_want;

    three_wire_adc_command_master_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic frame_seg_t seg_of(twadc_pkg::seg_kind_t kind, int unsigned len,
                                          logic [7:0] bits);
        frame_seg_t fs;
        fs.kind = kind;
        fs.len  = len;
        fs.bits = bits;
        return fs;
    endfunction

    // segment idx of the frame program for a request type
    function automatic frame_seg_t frame_seg(logic [1:0] req, logic [5:0] idx);
        frame_seg_t fs;
        fs = seg_of(twadc_pkg::K_END, 1, 8'h00);
        case (req)
            twadc_pkg::REQ_SETUP: begin
                case (idx)
                    6'd0: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_CTRL[7:5]});
                    6'd1: fs = seg_of(twadc_pkg::K_SEND, 4, {4'd0, ctrl_nibble});
                    6'd3: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_ATTR[7:5]});
                    6'd4: fs = seg_of(twadc_pkg::K_SEND, 8, attr_mask);
                    6'd6: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_WAKE[7:5]});
                    6'd7: fs = seg_of(twadc_pkg::K_SEND, 8, wake_mask);
                    6'd2, 6'd5, 6'd8: fs = seg_of(twadc_pkg::K_IDLE, 1, 8'h00);
                    default: ;
                endcase
            end
            twadc_pkg::REQ_PWDN: begin
                case (idx)
                    6'd0: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_CTRL[7:5]});
                    6'd1: fs = seg_of(twadc_pkg::K_SEND, 4, {4'd0, twadc_pkg::PWDN_CTRL});
                    6'd3: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_PWDN[7:5]});
                    6'd2, 6'd4: fs = seg_of(twadc_pkg::K_IDLE, 1, 8'h00);
                    default: ;
                endcase
            end
            twadc_pkg::REQ_CONVERT: begin
                case (idx)
                    6'd0: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_CONV[7:5]});
                    6'd1: fs = seg_of(twadc_pkg::K_SEND, 4, {4'd0, run_chan, 1'b0});
                    6'd2: fs = seg_of(twadc_pkg::K_PULSE, 1, 8'h00);
                    6'd3: fs = seg_of(twadc_pkg::K_RECV, unsigned'(twadc_pkg::READ_BITS), 8'h00);
                    6'd4: fs = seg_of(twadc_pkg::K_IDLE, 1, 8'h00);
                    default: ;
                endcase
            end
            default: begin
                case (idx)
                    6'd0: fs = seg_of(twadc_pkg::K_SEND, 3, {5'd0, twadc_pkg::OP_DIG[7:5]});
                    6'd1: fs = seg_of(twadc_pkg::K_RECV, unsigned'(twadc_pkg::READ_BITS), 8'h00);
                    6'd2: fs = seg_of(twadc_pkg::K_IDLE, 1, 8'h00);
                    default: ;
                endcase
            end
        endcase
        return fs;
    endfunction

    // line levels of one bit slot, advancing the predicted sequencer
    function automatic twadc_pkg::res_t slot_levels(twadc_pkg::req_t beat);
        twadc_pkg::res_t r;
        frame_seg_t      fs;
        r = '0;
        r.start_level = 1'b1;
        if (frame_idx == 6'd0 && beat.req_valid) begin
            run_req        = beat.req_type;
            run_chan       = beat.channel;
            frame_idx      = 6'd1;
            bit_idx        = 0;
            rx_byte        = 8'h00;
            r.req_accepted = 1'b1;
        end
        if (frame_idx != 6'd0) begin
            r.busy_res = 1'b1;
            fs = frame_seg(run_req, frame_idx - 6'd1);
            if (bit_idx >= fs.len) bit_idx = 0;
            case (fs.kind)
                twadc_pkg::K_SEND: begin
                    r.start_level = 1'b0;
                    r.clk_pulse   = 1'b1;
                    r.dio_drive   = 1'b1;
                    r.dio_level   = fs.bits[fs.len - 1 - bit_idx];
                end
                twadc_pkg::K_PULSE: begin
                    r.start_level = 1'b0;
                    r.clk_pulse   = 1'b1;
                    r.dio_drive   = 1'b1;
                end
                twadc_pkg::K_RECV: begin
                    r.start_level = 1'b0;
                    r.clk_pulse   = 1'b1;
                    rx_byte = {rx_byte[6:0], beat.dio_in};
                    if (bit_idx + 1 == fs.len) begin
                        r.read_valid = 1'b1;
                        r.read_data  = rx_byte;
                    end
                end
                default: ;
            endcase
            bit_idx++;
            if (bit_idx >= fs.len || fs.kind == twadc_pkg::K_END) begin
                bit_idx   = 0;
                frame_idx = frame_idx + 6'd1;
                if (frame_seg(run_req, frame_idx - 6'd1).kind == twadc_pkg::K_END) begin
                    frame_idx = 6'd0;
                end
            end
            bit_idx = bit_idx & 32'hF;
        end
        return r;
    endfunction

    function automatic stim_row_t dir_row(bit settle, bit valid, logic [1:0] kind,
                                          logic [2:0] chan, bit dio, bit has_exp,
                                          twadc_pkg::res_t exp);
        stim_row_t row;
        row.settle         = settle;
        row.has_exp        = has_exp;
        row.exp            = exp;
        row.beat.req_valid = valid;
        row.beat.req_type  = kind;
        row.beat.channel   = chan;
        row.beat.dio_in    = dio;
        return row;
    endfunction

    // offer one beat, with random idle cycles ahead of it, and log its expected slot
    task automatic send_slot(input twadc_pkg::req_t beat, input bit has_exp,
                             input twadc_pkg::res_t exp);
        twadc_pkg::res_t want;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, beat};
        do @(posedge aclk); while (!s_tready);
        want = slot_levels(beat);
        expected_slots.push_back(has_exp ? exp : want);
        @(negedge aclk);
    endtask

    // plain ticks until the running sequence has ended
    task automatic settle(input bit dio_rand, input bit dio_val);
        twadc_pkg::req_t tick;
        while (frame_idx != 6'd0) begin
            tick        = '0;
            tick.dio_in = dio_rand ? 1'($urandom_range(1)) : dio_val;
            send_slot(tick, 1'b0, '0);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_slots.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [twadc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            twadc_pkg::REG_CONTROL_NIBBLE: ctrl_nibble = val[3:0];
            twadc_pkg::REG_ATTRIBUTE_MASK: attr_mask   = val;
            twadc_pkg::REG_WAKEUP_MASK:    wake_mask   = val;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // result monitor, compares each beat with the oldest expected slot
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = twadc_pkg::res_t'(m_tdata[14:0]);
            if (expected_slots.size() == 0) begin
                $error("unexpected result beat %0h", m_tdata);
                mismatches++;
            end else begin
                mon_want = expected_slots.pop_front();
                check_field("start_level", 8'(mon_want.start_level),
                            8'(mon_got.start_level));
                check_field("clk_pulse", 8'(mon_want.clk_pulse), 8'(mon_got.clk_pulse));
                check_field("dio_drive", 8'(mon_want.dio_drive), 8'(mon_got.dio_drive));
                check_field("dio_level", 8'(mon_want.dio_level), 8'(mon_got.dio_level));
                check_field("read_valid", 8'(mon_want.read_valid), 8'(mon_got.read_valid));
                check_field("read_data", mon_want.read_data, mon_got.read_data);
                check_field("busy_res", 8'(mon_want.busy_res), 8'(mon_got.busy_res));
                check_field("req_accepted", 8'(mon_want.req_accepted),
                            8'(mon_got.req_accepted));
            end
        end
    end

    // receiver ready, with random stalls and an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready  = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL three_wire_adc_command_master_core");
            $finish;
        end
    end

    // stimulus
    initial begin
        frame_idx   = 6'd0;
        bit_idx     = 0;
        rx_byte     = 8'h00;
        run_req     = twadc_pkg::REQ_SETUP;
        run_chan    = 3'd0;
        ctrl_nibble = 4'h0;
        attr_mask   = 8'h00;
        wake_mask   = 8'h00;

        // directed: every request type, busy requests, all-ones and all-zeros reads
        dir_rows = '{
            dir_row(1'b0, 1'b0, twadc_pkg::REQ_SETUP,   3'd0, 1'b0, 1'b1, SLOT_IDLE),
            dir_row(1'b0, 1'b0, twadc_pkg::REQ_DIGITAL, 3'd7, 1'b1, 1'b1, SLOT_IDLE),
            dir_row(1'b0, 1'b1, twadc_pkg::REQ_SETUP,   3'd0, 1'b0, 1'b1, SLOT_SETUP_FIRST),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_DIGITAL, 3'd7, 1'b1, 1'b0, '0),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_PWDN,    3'd5, 1'b1, 1'b0, '0),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_CONVERT, 3'd7, 1'b1, 1'b0, '0),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_CONVERT, 3'd0, 1'b0, 1'b0, '0),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_DIGITAL, 3'd0, 1'b1, 1'b0, '0),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_DIGITAL, 3'd3, 1'b0, 1'b0, '0),
            dir_row(1'b0, 1'b1, twadc_pkg::REQ_CONVERT, 3'd2, 1'b1, 1'b0, '0),
            dir_row(1'b1, 1'b1, twadc_pkg::REQ_CONVERT, 3'd5, 1'b0, 1'b0, '0)
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_gap_pct = 27;
        recv_gap_pct = 68;
        foreach (dir_rows[i]) begin
            send_slot(dir_rows[i].beat, dir_rows[i].has_exp, dir_rows[i].exp);
            if (dir_rows[i].settle) settle(1'b0, dir_rows[i].beat.dio_in);
        end

        // random phases: receiver idles most, then sender idles most, then no idling
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                send_gap_pct = 27;
                recv_gap_pct = 68;
            end else if (phase < 2 * PHASES / 3) begin
                send_gap_pct = 68;
                recv_gap_pct = 27;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            settle(1'b1, 1'b0);
            drain();
            if (phase == 0) begin
                write_reg(twadc_pkg::REG_CONTROL_NIBBLE, 8'h00);
                write_reg(twadc_pkg::REG_ATTRIBUTE_MASK, 8'h00);
                write_reg(twadc_pkg::REG_WAKEUP_MASK, 8'h00);
            end else if (phase == 1) begin
                write_reg(twadc_pkg::REG_CONTROL_NIBBLE, 8'hFF);
                write_reg(twadc_pkg::REG_ATTRIBUTE_MASK, 8'hFF);
                write_reg(twadc_pkg::REG_WAKEUP_MASK, 8'hFF);
            end else begin
                write_reg(twadc_pkg::REG_CONTROL_NIBBLE, 8'($urandom_range(255)));
                write_reg(twadc_pkg::REG_ATTRIBUTE_MASK, 8'($urandom_range(255)));
                write_reg(twadc_pkg::REG_WAKEUP_MASK, 8'($urandom_range(255)));
            end
            if (phase == 2) write_reg(REG_UNUSED, 8'($urandom_range(255)));
            // long receiver hold-off while the sender keeps offering
            if (phase == 1) hold_request++;

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                next_beat.req_type = 2'($urandom_range(3));
                next_beat.channel  = 3'($urandom_range(7));
                next_beat.dio_in   = 1'($urandom_range(1));
                // idle: mostly start a request; busy: a few requests that must be ignored
                if (frame_idx == 6'd0) next_beat.req_valid = ($urandom_range(99) < 80);
                else next_beat.req_valid = ($urandom_range(99) < 20);
                send_slot(next_beat, 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("PASS three_wire_adc_command_master_core");
        end else begin
            $display("FAIL three_wire_adc_command_master_core");
        end
        $finish;
    end

endmodule
